FILE: src/srsw_pkg.sv
// shared types, codes and defaults of the selective-repeat sender window
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

    // parameter defaults
    localparam int MAX_PKTS_DEF    = 16;
    localparam int WINDOW_DEF      = 8;
    localparam int CHUNK_BYTES_DEF = 8;

    // field widths
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int TIME_W  = 32;
    localparam int RTO_W   = 16;
    localparam int CWND_W  = 15;
    localparam int RTT_W   = 19;
    localparam int RETRY_W = 8;

    // register indexes
    localparam logic [2:0] REG_INIT_RTO  = 3'd0;
    localparam logic [2:0] REG_MIN_RTO   = 3'd1;
    localparam logic [2:0] REG_MAX_RTO   = 3'd2;
    localparam logic [2:0] REG_INIT_THR  = 3'd3;
    localparam logic [2:0] REG_RETRY_LIM = 3'd4;

    // register reset values
    localparam logic [15:0] INIT_RTO_RST  = 16'd400;
    localparam logic [15:0] MIN_RTO_RST   = 16'd120;
    localparam logic [15:0] MAX_RTO_RST   = 16'd1500;
    localparam logic [6:0]  INIT_THR_RST  = 7'd8;
    localparam logic [7:0]  RETRY_LIM_RST = 8'd15;

    // command codes
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_RETX   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [2:0] STAT_RUN    = 3'd0;
    localparam logic [2:0] STAT_DONE   = 3'd1;
    localparam logic [2:0] STAT_FAIL   = 3'd2;
    localparam logic [2:0] STAT_IGNORE = 3'd3;
    localparam logic [2:0] STAT_DUP    = 3'd4;

    // one packet in q7.8
    localparam logic [CWND_W-1:0] CWND_ONE = 15'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ACK_SAMPLE,
        ST_ACK_SMOOTH,
        ST_ACK_RTO,
        ST_ACK_GROW,
        ST_ACK_DIV,
        ST_SLIDE,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_SEND,
        ST_STATUS
    } srsw_state_t;

endpackage

`default_nettype wire

FILE: src/srsw_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module srsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/srsw_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module srsw_div #(
    parameter int N = 17,
    parameter int D = 15
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [N-1:0] dividend,
    input  wire logic [D-1:0] divisor,
    output logic              done,
    output logic      [N-1:0] quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [N-1:0]     dvd_reg,  dvd_next;
    logic [N-1:0]     quo_reg,  quo_next;
    logic [D-1:0]     rem_reg,  rem_next;
    logic [D-1:0]     dsr_reg,  dsr_next;
    logic [D:0]       shifted;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[N-1]};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(N);
            dvd_next = dividend;
            quo_next = '0;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[N-2:0], 1'b0};
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = D'(shifted - {1'b0, dsr_reg});
                quo_next = {quo_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[D-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/selective_repeat_sender_window_unit.sv
// selective-repeat arq sender window with jacobson retransmission timer
// uses srsw_pkg, srsw_ram (send times) and srsw_div (window increment)
// sequence: decode, then an ack with rtt sample takes the sample, smooth and rto
// steps, a congestion-avoidance ack waits for the 17-bit divider, and the window
// slides one step per acked packet; a timeout scans each entry between base and
// next; one item at a time
// reset: transfer idle, window one packet, rto at initial register value
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_sender_window_unit #(
    parameter int MAX_PKTS    = srsw_pkg::MAX_PKTS_DEF,
    parameter int WINDOW      = srsw_pkg::WINDOW_DEF,
    parameter int CHUNK_BYTES = srsw_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  message_length,
    input  wire logic [7:0]  ack_number,
    input  wire logic        ack_flag,
    input  wire logic [31:0] now_ms,
    // result items
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [1:0]  kind,
    output logic      [7:0]  seq_number,
    output logic      [2:0]  status,
    output logic      [14:0] window_q8,
    output logic      [15:0] rto_ms,
    output logic             last
);

    localparam int IW = (MAX_PKTS > 1) ? $clog2(MAX_PKTS) : 1;
    localparam int CW = $clog2(MAX_PKTS + 1);
    // ceil(len / chunk) by reciprocal multiply, exact for sums below 2^9
    localparam int RSH = 18;
    localparam logic [18:0] RECIP = 19'((2 ** RSH + CHUNK_BYTES - 1) / CHUNK_BYTES);
    localparam logic [14:0] WMAX = 15'(WINDOW * 256);
    localparam logic [7:0] WIN8 = 8'(WINDOW);

    // ---------------- configuration registers ----------------
    logic [15:0] init_rto_reg;
    logic [15:0] min_rto_reg;
    logic [15:0] max_rto_reg;
    logic [6:0]  init_thr_reg;
    logic [7:0]  retry_lim_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_rto_reg  <= srsw_pkg::INIT_RTO_RST;
            min_rto_reg   <= srsw_pkg::MIN_RTO_RST;
            max_rto_reg   <= srsw_pkg::MAX_RTO_RST;
            init_thr_reg  <= srsw_pkg::INIT_THR_RST;
            retry_lim_reg <= srsw_pkg::RETRY_LIM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                srsw_pkg::REG_INIT_RTO:  init_rto_reg  <= pwdata[15:0];
                srsw_pkg::REG_MIN_RTO:   min_rto_reg   <= pwdata[15:0];
                srsw_pkg::REG_MAX_RTO:   max_rto_reg   <= pwdata[15:0];
                srsw_pkg::REG_INIT_THR:  init_thr_reg  <= pwdata[6:0];
                srsw_pkg::REG_RETRY_LIM: retry_lim_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            srsw_pkg::REG_INIT_RTO:  prdata = {16'd0, init_rto_reg};
            srsw_pkg::REG_MIN_RTO:   prdata = {16'd0, min_rto_reg};
            srsw_pkg::REG_MAX_RTO:   prdata = {16'd0, max_rto_reg};
            srsw_pkg::REG_INIT_THR:  prdata = {25'd0, init_thr_reg};
            srsw_pkg::REG_RETRY_LIM: prdata = {24'd0, retry_lim_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---------------- state ----------------
    srsw_pkg::srsw_state_t state_reg, state_next;

    // latched input item
    logic [1:0]  cmd_reg;
    logic [7:0]  len_reg;
    logic [7:0]  ackn_reg;
    logic        flag_reg;
    logic [31:0] now_reg;

    // transfer state
    logic                active_reg, active_next;
    logic [CW-1:0]       total_reg,  total_next;
    logic [CW-1:0]       base_reg,   base_next;
    logic [CW-1:0]       next_reg,   next_next;
    logic [CW-1:0]       scan_reg,   scan_next;
    logic [MAX_PKTS-1:0] acked_reg,  acked_next;
    logic [MAX_PKTS-1:0] sent_reg,   sent_next;
    logic [MAX_PKTS-1:0] sv_reg,     sv_next;
    logic [7:0]          retry_reg [MAX_PKTS];
    logic [7:0]          retry_next [MAX_PKTS];
    logic [2:0]          st_reg,     st_next;

    // rtt estimator and congestion control
    logic [18:0] srtt_reg, srtt_next;
    logic [18:0] rvar_reg, rvar_next;
    logic        seen_reg, seen_next;
    logic [15:0] samp_reg, samp_next;
    logic [15:0] rto_reg,  rto_next;
    logic [14:0] cwnd_reg, cwnd_next;
    logic [14:0] ssth_reg, ssth_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg,  kind_next;
    logic [7:0]  seq_reg,   seq_next;
    logic [2:0]  stat_reg,  stat_next;
    logic [14:0] win_reg,   win_next;
    logic [15:0] orto_reg,  orto_next;
    logic        last_reg,  last_next;

    // send time memory
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    // window increment divider
    logic        div_start;
    logic        div_done;
    logic [16:0] div_quo;

    srsw_ram #(
        .WIDTH (srsw_pkg::TIME_W),
        .DEPTH (MAX_PKTS)
    ) u_times (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (now_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    srsw_div #(
        .N (17),
        .D (srsw_pkg::CWND_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (17'h10000),
        .divisor  (cwnd_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------- shared conditions ----------------
    logic          out_free;
    logic [8:0]    ack9;
    logic [8:0]    ack_m1;
    logic          ack_ok;
    logic [IW-1:0] ack_idx;
    logic [27:0]   cnt_prod;
    logic [8:0]    cnt_raw;
    logic [CW-1:0] cnt;
    logic [IW-1:0] scan_idx;
    logic [IW-1:0] base_idx;
    logic [IW-1:0] next_idx;
    logic          scan_end;
    logic          scan_skip;
    logic          expired;
    logic          retry_out;
    logic [7:0]    lim;
    logic          send_more;
    logic          base_adv;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != srsw_pkg::ST_IDLE);

    // ack number must name a packet sent and not yet slid out
    assign ack9    = {1'b0, ackn_reg};
    assign ack_m1  = ack9 - 9'd1;
    assign ack_idx = ack_m1[IW-1:0];
    assign ack_ok  = flag_reg && (ack9 >= 9'd1) && (ack9 <= 9'(total_reg))
                     && (ack_m1 >= 9'(base_reg)) && (ack_m1 < 9'(next_reg));

    // packet count of a new message, saturated
    assign cnt_prod = (28'(len_reg) + 28'(CHUNK_BYTES - 1)) * 28'(RECIP);
    assign cnt_raw  = cnt_prod[RSH +: 9];
    assign cnt      = (cnt_raw > 9'(MAX_PKTS)) ? CW'(MAX_PKTS) : CW'(cnt_raw);

    assign scan_idx  = scan_reg[IW-1:0];
    assign base_idx  = base_reg[IW-1:0];
    assign next_idx  = next_reg[IW-1:0];
    assign scan_end  = (scan_reg >= next_reg);
    assign scan_skip = acked_reg[scan_idx] || !sent_reg[scan_idx];
    assign expired   = ((now_reg - ram_rdata) >= {16'd0, rto_reg});
    assign retry_out = (retry_reg[scan_idx] >= retry_lim_reg);
    assign base_adv  = (base_reg < total_reg) && acked_reg[base_idx];

    // packets allowed in flight: floor(cwnd) clamped to [1, window]
    always_comb
    begin
        lim = {1'b0, cwnd_reg[14:8]};
        if (lim < 8'd1)
        begin
            lim = 8'd1;
        end
        if (lim > WIN8)
        begin
            lim = WIN8;
        end
    end

    assign send_more = active_reg && (next_reg < total_reg)
                       && (9'(next_reg) < (9'(base_reg) + {1'b0, lim}));

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srsw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = srsw_pkg::ST_DECODE;
                end
            end
            srsw_pkg::ST_DECODE:
            begin
                if (cmd_reg == srsw_pkg::CMD_ACK && active_reg && ack_ok)
                begin
                    if (acked_reg[ack_idx])
                    begin
                        state_next = srsw_pkg::ST_SLIDE;
                    end
                    else if (sv_reg[ack_idx])
                    begin
                        state_next = srsw_pkg::ST_ACK_SAMPLE;
                    end
                    else
                    begin
                        state_next = srsw_pkg::ST_ACK_GROW;
                    end
                end
                else if (cmd_reg == srsw_pkg::CMD_TIMEOUT && active_reg)
                begin
                    state_next = srsw_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = srsw_pkg::ST_SEND;
                end
            end
            srsw_pkg::ST_ACK_SAMPLE: state_next = srsw_pkg::ST_ACK_SMOOTH;
            srsw_pkg::ST_ACK_SMOOTH: state_next = srsw_pkg::ST_ACK_RTO;
            srsw_pkg::ST_ACK_RTO:    state_next = srsw_pkg::ST_ACK_GROW;
            srsw_pkg::ST_ACK_GROW:
            begin
                state_next = (cwnd_reg < ssth_reg) ? srsw_pkg::ST_SLIDE
                                                   : srsw_pkg::ST_ACK_DIV;
            end
            srsw_pkg::ST_ACK_DIV:
            begin
                if (div_done)
                begin
                    state_next = srsw_pkg::ST_SLIDE;
                end
            end
            srsw_pkg::ST_SLIDE:
            begin
                if (!base_adv)
                begin
                    state_next = srsw_pkg::ST_SEND;
                end
            end
            srsw_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = srsw_pkg::ST_SEND;
                end
                else if (!scan_skip)
                begin
                    state_next = srsw_pkg::ST_SCAN_CHK;
                end
            end
            srsw_pkg::ST_SCAN_CHK:
            begin
                if (!expired)
                begin
                    state_next = srsw_pkg::ST_SCAN;
                end
                else if (retry_out)
                begin
                    state_next = srsw_pkg::ST_SEND;
                end
                else if (out_free)
                begin
                    state_next = srsw_pkg::ST_SCAN;
                end
            end
            srsw_pkg::ST_SEND:
            begin
                if (!send_more)
                begin
                    state_next = srsw_pkg::ST_STATUS;
                end
            end
            srsw_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    state_next = srsw_pkg::ST_IDLE;
                end
            end
            default: state_next = srsw_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        logic [31:0] elapsed;
        logic [18:0] s8;
        logic [18:0] err;
        logic [21:0] acc;
        logic [18:0] rto_raw;
        logic [15:0] sum16;
        logic [14:0] half;
        logic        emit;

        elapsed = now_reg - ram_rdata;
        s8      = {samp_reg, 3'b000};
        err     = (srtt_reg > s8) ? (srtt_reg - s8) : (s8 - srtt_reg);
        acc     = '0;
        rto_raw = '0;
        sum16   = '0;
        half    = '0;
        emit    = 1'b0;

        active_next = active_reg;
        total_next  = total_reg;
        base_next   = base_reg;
        next_next   = next_reg;
        scan_next   = scan_reg;
        acked_next  = acked_reg;
        sent_next   = sent_reg;
        sv_next     = sv_reg;
        retry_next  = retry_reg;
        st_next     = st_reg;
        srtt_next   = srtt_reg;
        rvar_next   = rvar_reg;
        seen_next   = seen_reg;
        samp_next   = samp_reg;
        rto_next    = rto_reg;
        cwnd_next   = cwnd_reg;
        ssth_next   = ssth_reg;

        kind_next = kind_reg;
        seq_next  = seq_reg;
        stat_next = stat_reg;
        win_next  = win_reg;
        orto_next = orto_reg;
        last_next = last_reg;

        ram_we    = 1'b0;
        ram_waddr = next_idx;
        ram_re    = 1'b0;
        ram_raddr = ack_idx;
        div_start = 1'b0;

        unique case (state_reg)
            srsw_pkg::ST_DECODE:
            begin
                case (cmd_reg)
                    srsw_pkg::CMD_START:
                    begin
                        // abort anything running and open a new transfer
                        acked_next = '0;
                        sent_next  = '0;
                        sv_next    = '0;
                        for (int i = 0; i < MAX_PKTS; i++)
                        begin
                            retry_next[i] = '0;
                        end
                        srtt_next   = '0;
                        rvar_next   = '0;
                        seen_next   = 1'b0;
                        rto_next    = init_rto_reg;
                        cwnd_next   = srsw_pkg::CWND_ONE;
                        ssth_next   = {init_thr_reg, 8'd0};
                        total_next  = cnt;
                        base_next   = '0;
                        next_next   = '0;
                        active_next = (cnt != '0);
                        st_next     = (cnt != '0) ? srsw_pkg::STAT_RUN
                                                  : srsw_pkg::STAT_DONE;
                    end
                    srsw_pkg::CMD_ACK:
                    begin
                        st_next = srsw_pkg::STAT_IGNORE;
                        if (active_reg && ack_ok)
                        begin
                            if (acked_reg[ack_idx])
                            begin
                                st_next = srsw_pkg::STAT_DUP;
                            end
                            else
                            begin
                                acked_next[ack_idx] = 1'b1;
                                st_next             = srsw_pkg::STAT_RUN;
                                // never retransmitted: fetch send time for a sample
                                ram_re = sv_reg[ack_idx];
                            end
                        end
                    end
                    srsw_pkg::CMD_TIMEOUT:
                    begin
                        st_next   = active_reg ? srsw_pkg::STAT_RUN
                                               : srsw_pkg::STAT_IGNORE;
                        scan_next = base_reg;
                    end
                    default: st_next = srsw_pkg::STAT_IGNORE;
                endcase
            end
            srsw_pkg::ST_ACK_SAMPLE:
            begin
                // rtt sample saturated to [1, 65535]
                if (elapsed > 32'd65535)
                begin
                    samp_next = 16'hFFFF;
                end
                else if (elapsed == 32'd0)
                begin
                    samp_next = 16'd1;
                end
                else
                begin
                    samp_next = elapsed[15:0];
                end
            end
            srsw_pkg::ST_ACK_SMOOTH:
            begin
                if (!seen_reg)
                begin
                    srtt_next = s8;
                    rvar_next = {1'b0, samp_reg, 2'b00};
                    seen_next = 1'b1;
                end
                else
                begin
                    acc       = ({3'd0, rvar_reg} << 1) + {3'd0, rvar_reg} + {3'd0, err};
                    rvar_next = acc[20:2];
                    acc       = ({3'd0, srtt_reg} << 3) - {3'd0, srtt_reg} + {3'd0, s8};
                    srtt_next = acc[21:3];
                end
            end
            srsw_pkg::ST_ACK_RTO:
            begin
                // rto = ceil((srtt + 4*rttvar) / 8), clamped
                acc     = {3'd0, srtt_reg} + ({3'd0, rvar_reg} << 2) + 22'd7;
                rto_raw = acc[21:3];
                if (rto_raw < {3'd0, min_rto_reg})
                begin
                    rto_next = min_rto_reg;
                end
                else if (rto_raw > {3'd0, max_rto_reg})
                begin
                    rto_next = max_rto_reg;
                end
                else
                begin
                    rto_next = rto_raw[15:0];
                end
            end
            srsw_pkg::ST_ACK_GROW:
            begin
                if (cwnd_reg < ssth_reg)
                begin
                    // slow start
                    sum16     = {1'b0, cwnd_reg} + 16'd256;
                    cwnd_next = (sum16 > {1'b0, WMAX}) ? WMAX : sum16[14:0];
                end
                else
                begin
                    // congestion avoidance: add 65536 / cwnd
                    div_start = 1'b1;
                end
            end
            srsw_pkg::ST_ACK_DIV:
            begin
                if (div_done)
                begin
                    sum16     = {1'b0, cwnd_reg} + div_quo[15:0];
                    cwnd_next = (sum16 > {1'b0, WMAX}) ? WMAX : sum16[14:0];
                end
            end
            srsw_pkg::ST_SLIDE:
            begin
                if (base_adv)
                begin
                    base_next = base_reg + CW'(1);
                end
                else if (base_reg >= total_reg)
                begin
                    active_next = 1'b0;
                    st_next     = srsw_pkg::STAT_DONE;
                end
            end
            srsw_pkg::ST_SCAN:
            begin
                ram_raddr = scan_idx;
                if (!scan_end)
                begin
                    if (scan_skip)
                    begin
                        scan_next = scan_reg + CW'(1);
                    end
                    else
                    begin
                        ram_re = 1'b1;
                    end
                end
            end
            srsw_pkg::ST_SCAN_CHK:
            begin
                ram_waddr = scan_idx;
                if (!expired)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                else if (retry_out)
                begin
                    // retry budget spent: stop the transfer
                    active_next = 1'b0;
                    st_next     = srsw_pkg::STAT_FAIL;
                end
                else if (out_free)
                begin
                    retry_next[scan_idx] = retry_reg[scan_idx] + 8'd1;
                    sv_next[scan_idx]    = 1'b0;
                    ram_we               = 1'b1;
                    // halve threshold, window back to one packet
                    half = {1'b0, cwnd_reg[14:1]};
                    if (half < srsw_pkg::CWND_ONE)
                    begin
                        ssth_next = srsw_pkg::CWND_ONE;
                    end
                    else if (half > WMAX)
                    begin
                        ssth_next = WMAX;
                    end
                    else
                    begin
                        ssth_next = half;
                    end
                    cwnd_next = srsw_pkg::CWND_ONE;
                    emit      = 1'b1;
                    kind_next = srsw_pkg::KIND_RETX;
                    seq_next  = 8'(scan_reg) + 8'd1;
                    stat_next = srsw_pkg::STAT_RUN;
                    win_next  = srsw_pkg::CWND_ONE;
                    orto_next = rto_reg;
                    last_next = 1'b0;
                    scan_next = scan_reg + CW'(1);
                end
            end
            srsw_pkg::ST_SEND:
            begin
                if (send_more && out_free)
                begin
                    sent_next[next_idx] = 1'b1;
                    sv_next[next_idx]   = 1'b1;
                    ram_we              = 1'b1;
                    emit                = 1'b1;
                    kind_next           = srsw_pkg::KIND_SEND;
                    seq_next            = 8'(next_reg) + 8'd1;
                    stat_next           = srsw_pkg::STAT_RUN;
                    win_next            = cwnd_reg;
                    orto_next           = rto_reg;
                    last_next           = 1'b0;
                    next_next           = next_reg + CW'(1);
                end
            end
            srsw_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    kind_next = srsw_pkg::KIND_STATUS;
                    seq_next  = 8'd0;
                    stat_next = st_reg;
                    win_next  = cwnd_reg;
                    orto_next = rto_reg;
                    last_next = 1'b1;
                end
            end
            default: ;
        endcase

        // output register: load on emit, drop once taken
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srsw_pkg::ST_IDLE;
            active_reg    <= 1'b0;
            total_reg     <= '0;
            base_reg      <= '0;
            next_reg      <= '0;
            scan_reg      <= '0;
            acked_reg     <= '0;
            sent_reg      <= '0;
            sv_reg        <= '0;
            for (int i = 0; i < MAX_PKTS; i++)
            begin
                retry_reg[i] <= '0;
            end
            st_reg        <= srsw_pkg::STAT_IGNORE;
            srtt_reg      <= '0;
            rvar_reg      <= '0;
            seen_reg      <= 1'b0;
            rto_reg       <= srsw_pkg::INIT_RTO_RST;
            cwnd_reg      <= srsw_pkg::CWND_ONE;
            ssth_reg      <= {srsw_pkg::INIT_THR_RST, 8'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            total_reg     <= total_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            scan_reg      <= scan_next;
            acked_reg     <= acked_next;
            sent_reg      <= sent_next;
            sv_reg        <= sv_next;
            retry_reg     <= retry_next;
            st_reg        <= st_next;
            srtt_reg      <= srtt_next;
            rvar_reg      <= rvar_next;
            seen_reg      <= seen_next;
            rto_reg       <= rto_next;
            cwnd_reg      <= cwnd_next;
            ssth_reg      <= ssth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == srsw_pkg::ST_IDLE && in_valid)
        begin
            cmd_reg  <= cmd;
            len_reg  <= message_length;
            ackn_reg <= ack_number;
            flag_reg <= ack_flag;
            now_reg  <= now_ms;
        end
        samp_reg <= samp_next;
        kind_reg <= kind_next;
        seq_reg  <= seq_next;
        stat_reg <= stat_next;
        win_reg  <= win_next;
        orto_reg <= orto_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign seq_number = seq_reg;
    assign status     = stat_reg;
    assign window_q8  = win_reg;
    assign rto_ms     = orto_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire
